[rtl/pid_page_range_remap_table_defines.svh]
// Assertion macros for the page range remap table.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef PID_PAGE_RANGE_REMAP_TABLE_DEFINES_SVH
`define PID_PAGE_RANGE_REMAP_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge outside reset
`define PPRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every rising edge, reset included
`define PPRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/pprt_pkg.sv]
// Shared types and constants of the page range remap table.
// No dependencies; used by the interfaces, the entry RAM, the evaluator and the top level.
package pprt_pkg;

  localparam int DEF_TABLE_DEPTH = 256;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FAULT  = 2'd2;
  localparam logic [1:0] REQ_BKPT   = 2'd3;

  // breakpoint reverse-map window, and its negation (-4096)
  localparam logic [31:0] BKPT_WINDOW     = 32'd4096;
  localparam logic [31:0] BKPT_NEG_WINDOW = 32'hFFFF_F000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] process_id;
    logic [31:0] page_base;
    logic [31:0] relocated_base;
    logic [30:0] region_size;
    logic [31:0] fault_address;
    logic [31:0] instr_address;
    logic        err_present;
    logic        err_user;
    logic        err_fetch;
  } req_t;

  typedef struct packed {
    logic        op_ok;
    logic        fault_handled;
    logic        instr_changed;
    logic [31:0] new_instr_address;
  } rsp_t;

  // one table region
  typedef struct packed {
    logic [31:0] pid;
    logic [31:0] orig_base;
    logic [31:0] reloc_base;
    logic [30:0] length;
  } entry_t;

  // per-entry match results handed from the evaluator to the sequencer
  typedef struct packed {
    logic        pid_eq;
    logic        base_eq;
    logic        fault_hit;
    logic        bkpt_hit;
    logic [31:0] fault_diff;
    logic [31:0] bkpt_off;
  } eval_t;

endpackage

[rtl/pprt_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on pprt_pkg for the payload types.
interface pprt_req_if import pprt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pprt_rsp_if import pprt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/pid_page_range_remap_table.sv]
// Top level of the page range remap table: sequencer, entry count and response register.
// Depends on pprt_pkg, pprt_if, pprt_entry_ram, pprt_entry_eval and the defines header.
//
//  channel  | direction | payload | handshake
//  ---------+-----------+---------+-------------------------
//  in_req   | sink      | req_t   | valid/ready, 1 request
//  out_rsp  | source    | rsp_t   | valid/ready, 1 response
//
// A request walks the table one entry per cycle through the RAM read port; the response
// is posted when the walk ends. Add and fault stop at the first hit. A remove that hits
// entry i then moves entries i+1..n-1 down (n stored entries), one per cycle, and posts.
// Reset empties the table (count to zero); the storage itself is not cleared.
// The response register frees the sequencer while a response waits on out_rsp.
`include "pid_page_range_remap_table_defines.svh"
module pid_page_range_remap_table
  import pprt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  pprt_req_if.sink   in_req,
  pprt_rsp_if.source out_rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT, ST_FIN} state_t;

  state_t        state_r;
  req_t          req_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] rd_idx_r;
  logic [CW-1:0] pidx_r;
  logic          pend_r;
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [31:0]   hit_pid_r;
  logic          found_r;
  logic [31:0]   add_a_r;
  logic [31:0]   add_b_r;
  logic          out_valid_r;
  rsp_t          out_data_r;

  logic          issue;
  logic          rm_hit;
  logic          fin_go;
  logic          has_room;
  logic [CW-1:0] pidx_m1;
  logic [31:0]   fin_addr;
  logic          fin_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  eval_t         ev;

  pprt_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  pprt_entry_eval u_eval (
    .req   (req_r),
    .entry (ram_rdata),
    .ev    (ev)
  );

  // read issue, completion and response value
  always_comb begin
    issue    = ((state_r == ST_SCAN) || (state_r == ST_SHIFT)) && (rd_idx_r < count_r);
    rm_hit   = (state_r == ST_SCAN) && pend_r && (req_r.req_type == REQ_REMOVE) &&
               ev.pid_eq && ev.base_eq;
    fin_go   = (state_r == ST_FIN) && (!out_valid_r || out_rsp.ready);
    has_room = (count_r < CW'(TABLE_DEPTH));
    pidx_m1  = pidx_r - CW'(1);
    fin_addr = found_r ? (add_a_r + add_b_r) : req_r.instr_address;
    fin_ok   = 1'b0;
    if (req_r.req_type == REQ_ADD) begin
      fin_ok = hit_r || has_room;
    end else if (req_r.req_type == REQ_REMOVE) begin
      fin_ok = hit_r;
    end
  end

  // RAM write: shift-down during remove, update or append at the end of add
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = ram_rdata;
    priority if ((state_r == ST_SHIFT) && pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pidx_m1[AW-1:0];
    end else if (fin_go && (req_r.req_type == REQ_ADD) && (hit_r || has_room)) begin
      ram_we    = 1'b1;
      ram_waddr = hit_r ? hit_idx_r : count_r[AW-1:0];
      ram_wdata = '{pid:        hit_r ? hit_pid_r : req_r.process_id,
                    orig_base:  req_r.page_base,
                    reloc_base: req_r.relocated_base,
                    length:     req_r.region_size};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // response register: load on finish, clear once taken
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end

      // read pipeline; a remove hit restarts the reads just past the hit entry
      pend_r <= issue && !rm_hit;
      if (issue) begin
        pidx_r <= rd_idx_r;
      end
      if (rm_hit) begin
        rd_idx_r <= pidx_r + CW'(1);
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_req.valid) begin
            req_r    <= in_req.data;
            rd_idx_r <= '0;
            hit_r    <= 1'b0;
            found_r  <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pend_r) begin
            unique case (req_r.req_type)
              REQ_ADD: begin
                if (ev.base_eq) begin
                  hit_r     <= 1'b1;
                  hit_idx_r <= pidx_r[AW-1:0];
                  hit_pid_r <= ram_rdata.pid;
                  state_r   <= ST_FIN;
                end
              end
              REQ_REMOVE: begin
                if (ev.pid_eq && ev.base_eq) begin
                  hit_r   <= 1'b1;
                  state_r <= ST_SHIFT;
                end
              end
              REQ_FAULT: begin
                if (ev.fault_hit) begin
                  found_r <= 1'b1;
                  add_a_r <= ram_rdata.reloc_base;
                  add_b_r <= ev.fault_diff;
                  state_r <= ST_FIN;
                end
              end
              REQ_BKPT: begin
                // last match wins, keep scanning
                if (ev.bkpt_hit) begin
                  found_r <= 1'b1;
                  add_a_r <= ram_rdata.orig_base;
                  add_b_r <= ev.bkpt_off;
                end
              end
              default: ;
            endcase
          end else if (!issue) begin
            state_r <= ST_FIN;
          end
        end
        ST_SHIFT: begin
          if (!pend_r && !issue) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_data_r  <= '{op_ok:             fin_ok,
                             fault_handled:     found_r && (req_r.req_type == REQ_FAULT),
                             instr_changed:     (fin_addr != req_r.instr_address),
                             new_instr_address: fin_addr};
            if ((req_r.req_type == REQ_ADD) && !hit_r && has_room) begin
              count_r <= count_r + CW'(1);
            end else if ((req_r.req_type == REQ_REMOVE) && hit_r) begin
              count_r <= count_r - CW'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_req.ready  = (state_r == ST_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // checks
  `PPRT_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(TABLE_DEPTH), "entry count above table depth")
  `PPRT_ASSERT(a_we_state, clk, rst_n, ram_we |-> ((state_r == ST_SHIFT) || (state_r == ST_FIN)), "table write outside shift or finish")
  `PPRT_ASSERT(a_we_bound, clk, rst_n, ram_we |-> ({1'b0, ram_waddr} <= {1'b0, count_r}), "table write beyond fill level")
  `PPRT_ASSERT(a_count_fin, clk, rst_n, !$stable(count_r) |-> $past(state_r == ST_FIN), "entry count changed outside finish")
  `PPRT_ASSERT(a_fin_rsp, clk, rst_n, fin_go |=> out_valid_r, "finished request left no response")

endmodule

[rtl/pprt_entry_ram.sv]
// Region table storage: one write port, one read port, registered read data.
// Depends on pprt_pkg for entry_t.
module pprt_entry_ram
  import pprt_pkg::*;
#(
  parameter int DEPTH = DEF_TABLE_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/pprt_entry_eval.sv]
// Match logic for one table entry against the current request.
// Depends on pprt_pkg for req_t, entry_t and eval_t.
module pprt_entry_eval
  import pprt_pkg::*;
(
  input  req_t   req,
  input  entry_t entry,
  output eval_t  ev
);

  logic [31:0] span_end;
  logic [31:0] eip;
  logic [31:0] limit;
  logic        qualify;
  logic        in_span;
  logic        in_window;

  always_comb begin
    // fault range is [base, base + length), wrapping at 32 bits
    span_end = entry.orig_base + {1'b0, entry.length};
    qualify  = req.err_present & req.err_user & req.err_fetch;
    in_span  = (req.fault_address >= entry.orig_base) && (req.fault_address < span_end);

    // breakpoint: offset of eip - 1 from the relocated copy, signed window
    eip       = req.instr_address - 32'd1;
    ev.bkpt_off = eip - entry.reloc_base;
    limit     = {1'b0, entry.length} + BKPT_WINDOW;
    in_window = ($signed(BKPT_NEG_WINDOW) < $signed(ev.bkpt_off)) &&
                ($signed(ev.bkpt_off) < $signed(limit));

    ev.pid_eq     = (entry.pid == req.process_id);
    ev.base_eq    = (entry.orig_base == req.page_base);
    ev.fault_hit  = qualify && ev.pid_eq && in_span;
    ev.fault_diff = req.instr_address - entry.orig_base;
    ev.bkpt_hit   = ev.pid_eq && in_window;
  end

endmodule

[sim/tb_pid_page_range_remap_table.sv]
`timescale 1ns / 100ps
// Self-checking testbench for pid_page_range_remap_table: directed, table-full and random
// request traffic, checked against a shadow copy of the region table kept here.
// Depends on pprt_pkg, pprt_if and the RTL of the block.
module tb_pid_page_range_remap_table;
  import pprt_pkg::*;

  localparam int TBL_DEPTH    = DEF_TABLE_DEPTH;
  localparam int DRAIN_CYCLES = 600;        // longer than a full walk plus a full shift
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam logic [2:0] ERR_ALL = 3'b111;

  logic clk;
  logic rst_n;

  pprt_req_if req_ch ();
  pprt_rsp_if rsp_ch ();

  pid_page_range_remap_table u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // shadow region table
  logic [31:0] tbl_pid   [TBL_DEPTH];
  logic [31:0] tbl_base  [TBL_DEPTH];
  logic [31:0] tbl_reloc [TBL_DEPTH];
  logic [30:0] tbl_len   [TBL_DEPTH];
  int          tbl_count = 0;

  // responses still owed by the block, oldest first
  rsp_t        pending_rsp_q[$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          error_cnt = 0;
  int unsigned cycle_cnt = 0;

  logic [31:0] pid_pool   [4];
  logic [31:0] reloc_pool [4];

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t ERROR timeout after %0d cycles", $time, cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // Table behavior: applies one request to the shadow table, returns its response
  function automatic rsp_t predict_remap(req_t r);
    rsp_t        res;
    int          hit;
    logic [31:0] stop;
    logic [31:0] eip;
    logic [31:0] off;
    logic [31:0] bound;
    res.op_ok             = 1'b0;
    res.fault_handled     = 1'b0;
    res.new_instr_address = r.instr_address;
    hit = -1;
    case (r.req_type)
      REQ_ADD: begin
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && tbl_base[i] == r.page_base) hit = i;
        if (hit >= 0) begin
          // same base updates in place, owner pid kept
          tbl_reloc[hit] = r.relocated_base;
          tbl_len[hit]   = r.region_size;
          res.op_ok      = 1'b1;
        end else if (tbl_count < TBL_DEPTH) begin
          tbl_pid[tbl_count]   = r.process_id;
          tbl_base[tbl_count]  = r.page_base;
          tbl_reloc[tbl_count] = r.relocated_base;
          tbl_len[tbl_count]   = r.region_size;
          tbl_count++;
          res.op_ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && tbl_pid[i] == r.process_id && tbl_base[i] == r.page_base) hit = i;
        if (hit >= 0) begin
          for (int j = hit; j + 1 < tbl_count; j++) begin
            tbl_pid[j]   = tbl_pid[j + 1];
            tbl_base[j]  = tbl_base[j + 1];
            tbl_reloc[j] = tbl_reloc[j + 1];
            tbl_len[j]   = tbl_len[j + 1];
          end
          tbl_count--;
          res.op_ok = 1'b1;
        end
      end
      REQ_FAULT: begin
        // only user-mode, present, instruction-fetch faults; first region wins
        if (r.err_present && r.err_user && r.err_fetch) begin
          for (int i = 0; i < tbl_count; i++) begin
            stop = tbl_base[i] + {1'b0, tbl_len[i]};
            if (hit < 0 && tbl_pid[i] == r.process_id &&
                r.fault_address >= tbl_base[i] && r.fault_address < stop) begin
              hit = i;
              res.new_instr_address = tbl_reloc[i] + (r.instr_address - tbl_base[i]);
              res.fault_handled     = 1'b1;
            end
          end
        end
      end
      default: begin
        // breakpoint: signed window around the relocated copy, last region wins
        eip = r.instr_address - 32'd1;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_pid[i] == r.process_id) begin
            off   = eip - tbl_reloc[i];
            bound = {1'b0, tbl_len[i]} + BKPT_WINDOW;
            if ($signed(BKPT_NEG_WINDOW) < $signed(off) && $signed(off) < $signed(bound))
              res.new_instr_address = tbl_base[i] + off;
          end
        end
      end
    endcase
    res.instr_changed = (res.new_instr_address != r.instr_address);
    return res;
  endfunction

  function automatic req_t mk_req(logic [1:0] kind, logic [31:0] pid, logic [31:0] base,
                                  logic [31:0] reloc, logic [30:0] size,
                                  logic [31:0] faddr, logic [31:0] instr, logic [2:0] err);
    req_t r;
    r.req_type       = kind;
    r.process_id     = pid;
    r.page_base      = base;
    r.relocated_base = reloc;
    r.region_size    = size;
    r.fault_address  = faddr;
    r.instr_address  = instr;
    r.err_present    = err[2];
    r.err_user       = err[1];
    r.err_fetch      = err[0];
    return r;
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(0, 19))
      0:       return 31'h7FFF_FFFF;
      1, 2:    return 31'($urandom);
      3:       return 31'd0;
      default: return 31'($urandom_range(1, 16)) << 12;
    endcase
  endfunction

  // Mostly well-formed requests aimed at stored regions, some pure noise
  function automatic req_t random_request();
    req_t        r;
    int          e;
    int          pick;
    logic [31:0] len32;
    logic [31:0] off;
    r.req_type       = 2'($urandom);
    r.process_id     = $urandom;
    r.page_base      = $urandom;
    r.relocated_base = $urandom;
    r.region_size    = 31'($urandom);
    r.fault_address  = $urandom;
    r.instr_address  = $urandom;
    {r.err_present, r.err_user, r.err_fetch} = 3'($urandom);
    if ($urandom_range(0, 99) < 10) return r;

    pick = $urandom_range(0, 99);
    if (tbl_count == 0) r.req_type = REQ_ADD;
    else if (pick < ((tbl_count > 40) ? 10 : 28)) r.req_type = REQ_ADD;
    else if (pick < 48) r.req_type = REQ_REMOVE;
    else if (pick < 74) r.req_type = REQ_FAULT;
    else r.req_type = REQ_BKPT;

    e     = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
    len32 = {1'b0, tbl_len[e]};
    case (r.req_type)
      REQ_ADD: begin
        r.process_id     = pid_pool[$urandom_range(0, 3)];
        r.relocated_base = reloc_pool[$urandom_range(0, 3)] + ($urandom_range(0, 15) << 12);
        r.region_size    = rand_size();
        if (tbl_count > 0 && $urandom_range(0, 2) == 0) r.page_base = tbl_base[e];
        else if ($urandom_range(0, 9) != 0) r.page_base[11:0] = 12'h000;
      end
      REQ_REMOVE: begin
        r.page_base  = tbl_base[e];
        r.process_id = ($urandom_range(0, 3) != 0) ? tbl_pid[e] : pid_pool[$urandom_range(0, 3)];
      end
      REQ_FAULT: begin
        r.process_id = ($urandom_range(0, 6) != 0) ? tbl_pid[e] : pid_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 3) != 0) {r.err_present, r.err_user, r.err_fetch} = ERR_ALL;
        case ($urandom_range(0, 4))
          0: r.fault_address = tbl_base[e] + ($urandom % (len32 + 32'd1));
          1: r.fault_address = tbl_base[e] + len32;
          2: r.fault_address = tbl_base[e] + len32 - 32'd1;
          3: r.fault_address = tbl_base[e] - 32'd1;
          default: r.fault_address = tbl_base[e];
        endcase
        if ($urandom_range(0, 1) == 0)
          r.instr_address = tbl_base[e] + ($urandom % (len32 + 32'd1));
      end
      default: begin
        r.process_id = ($urandom_range(0, 6) != 0) ? tbl_pid[e] : pid_pool[$urandom_range(0, 3)];
        case ($urandom_range(0, 4))
          0: off = $urandom_range(0, 8191) - 32'd4096;
          1: off = len32 + $urandom_range(0, 8191) - 32'd4096;
          2: off = $urandom % (len32 + 32'd1);
          3: off = ($urandom_range(0, 1) == 0) ? BKPT_NEG_WINDOW : len32 + BKPT_WINDOW - 32'd1;
          default: off = $urandom;
        endcase
        r.instr_address = tbl_reloc[e] + off + 32'd1;
      end
    endcase
    return r;
  endfunction

  // One request on the input channel; prediction at the accepting edge
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_rsp_q.push_back(predict_remap(r));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      error_cnt++;
      $display("%0t ERROR %s: expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  // Response side: random stalls, every accepted response checked in order
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        error_cnt++;
        $display("%0t ERROR response with none pending: expected nothing, got %h",
                 $time, rsp_ch.data);
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        compare_field("op_ok", 32'(exp_rsp.op_ok), 32'(rsp_ch.data.op_ok));
        compare_field("fault_handled", 32'(exp_rsp.fault_handled),
                      32'(rsp_ch.data.fault_handled));
        compare_field("instr_changed", 32'(exp_rsp.instr_changed),
                      32'(rsp_ch.data.instr_changed));
        compare_field("new_instr_address", exp_rsp.new_instr_address,
                      rsp_ch.data.new_instr_address);
      end
    end
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Edges of every request kind on a small hand-built table
  task automatic test_directed();
    logic [31:0] pid_a;
    logic [31:0] pid_b;
    pid_a = 32'hFFFF_FFFF;
    pid_b = 32'h1234_5678;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // empty table: nothing found
    send_request(mk_req(REQ_FAULT, pid_a, 0, 0, 0, 32'h0040_0000, 32'h0040_0123, ERR_ALL));
    send_request(mk_req(REQ_BKPT, pid_a, 0, 0, 0, 0, 32'h0000_0000, 3'b000));
    send_request(mk_req(REQ_REMOVE, pid_a, 32'h0040_0000, 0, 0, 0, 32'h1, 3'b000));
    // two regions of one pid, then an update of the first by base under another pid
    send_request(mk_req(REQ_ADD, pid_a, 32'h0040_0000, 32'h7000_0000, 31'd8192, 0,
                        32'hFFFF_FFFF, 3'b000));
    send_request(mk_req(REQ_ADD, pid_a, 32'h0080_0000, 32'h7100_2000, 31'd4096, 0, 0, 3'b000));
    send_request(mk_req(REQ_ADD, 32'h0, 32'h0040_0000, 32'h7100_0000, 31'd12288, 0, 0, 3'b000));
    // fault range: first byte, last byte, one past the end
    send_request(mk_req(REQ_FAULT, pid_a, 0, 0, 0, 32'h0040_0000, 32'h0040_0123, ERR_ALL));
    send_request(mk_req(REQ_FAULT, pid_a, 0, 0, 0, 32'h0040_2FFF, 32'h0040_2FFF, ERR_ALL));
    send_request(mk_req(REQ_FAULT, pid_a, 0, 0, 0, 32'h0040_3000, 32'h0040_0010, ERR_ALL));
    // faults that do not qualify
    for (int k = 0; k < 7; k++)
      send_request(mk_req(REQ_FAULT, pid_a, 0, 0, 0, 32'h0040_0000, 32'h0040_0123, 3'(k)));
    send_request(mk_req(REQ_FAULT, 32'h0, 0, 0, 0, 32'h0040_0000, 32'h0040_0123, ERR_ALL));
    // breakpoint: both regions match, the later one wins
    send_request(mk_req(REQ_BKPT, pid_a, 0, 0, 0, 0, 32'h7100_2801, 3'b000));
    // lower window edge inside and just outside
    send_request(mk_req(REQ_BKPT, pid_a, 0, 0, 0, 0, 32'h70FF_F002, 3'b000));
    send_request(mk_req(REQ_BKPT, pid_a, 0, 0, 0, 0, 32'h70FF_F001, 3'b000));
    // upper window edge inside and just outside
    send_request(mk_req(REQ_BKPT, pid_a, 0, 0, 0, 0, 32'h7100_4000, 3'b000));
    send_request(mk_req(REQ_BKPT, pid_a, 0, 0, 0, 0, 32'h7100_4001, 3'b000));
    // largest size: window bound and fault range both wrap
    send_request(mk_req(REQ_ADD, pid_b, 32'hFFFF_F000, 32'hFFFF_F000, 31'h7FFF_FFFF, 0, 0,
                        3'b000));
    send_request(mk_req(REQ_BKPT, pid_b, 0, 0, 0, 0, 32'hFFFF_F001, 3'b000));
    send_request(mk_req(REQ_FAULT, pid_b, 0, 0, 0, 32'hFFFF_F800, 32'hFFFF_FFFF, ERR_ALL));
    // remove: wrong pid misses, then hits shift the table down
    send_request(mk_req(REQ_REMOVE, 32'h0, 32'h0040_0000, 0, 0, 0, 0, 3'b000));
    send_request(mk_req(REQ_REMOVE, pid_a, 32'h0040_0000, 0, 0, 0, 0, 3'b000));
    send_request(mk_req(REQ_FAULT, pid_a, 0, 0, 0, 32'h0080_0000, 32'h0000_0000, ERR_ALL));
    send_request(mk_req(REQ_REMOVE, pid_a, 32'h0080_0000, 0, 0, 0, 0, 3'b000));
    send_request(mk_req(REQ_REMOVE, pid_b, 32'hFFFF_F000, 0, 0, 0, 0, 3'b000));
  endtask

  // Fill to capacity, refuse a new base, update an old one, then empty in random order
  task automatic test_table_full();
    int e;
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    while (tbl_count < TBL_DEPTH)
      send_request(mk_req(REQ_ADD, pid_pool[$urandom_range(0, 3)],
                          32'h1000_0000 + (32'(tbl_count) << 12), $urandom, rand_size(),
                          0, $urandom, 3'b000));
    // hold off until the block has answered everything
    wait_drained();
    send_request(mk_req(REQ_ADD, pid_pool[0], 32'h0FFF_F000, 32'h5000_0000, 31'd4096, 0, 0,
                        3'b000));
    send_request(mk_req(REQ_ADD, pid_pool[1], 32'h1000_0000 + (32'(TBL_DEPTH - 1) << 12),
                        32'h5000_0000, 31'd8192, 0, 0, 3'b000));
    for (int k = 0; k < 6; k++) send_request(random_request());
    while (tbl_count > 0) begin
      e = $urandom_range(0, tbl_count - 1);
      send_request(mk_req(REQ_REMOVE, tbl_pid[e], tbl_base[e], $urandom, 31'($urandom),
                          $urandom, $urandom, 3'b000));
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) send_request(random_request());
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  endtask

  // test sequence
  initial begin
    rst_n        <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    pid_pool[0]   = 32'h0000_0000;
    pid_pool[1]   = 32'hFFFF_FFFF;
    pid_pool[2]   = $urandom;
    pid_pool[3]   = $urandom;
    reloc_pool[0] = 32'h0000_0000;
    reloc_pool[1] = 32'hFFFF_8000;
    reloc_pool[2] = {20'($urandom_range(0, 32'hFFFFF)), 12'h000};
    reloc_pool[3] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 47, 0);
    test_random_traffic(240, 0, 47);
    test_random_traffic(240, 28, 28);
    finish_run();
  end

endmodule
